>>> sv/tpba_pkg.sv
// Shared types and constants for the two-pool bitmap allocator.
package tpba_pkg;

    localparam int WORD_W  = 32;   // map bits held in one memory word
    localparam int BIT_W   = 5;    // bit position within a map word
    localparam int ENTRY_W = 10;   // entry index width on the ports

    localparam int BLOCK_SIZE_W = 11;
    localparam int INODE_SIZE_W = 9;
    localparam int BLOCK_FREE_W = 11;
    localparam int INODE_FREE_W = 9;

    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 11'd1024;
    localparam logic [INODE_SIZE_W-1:0] INODE_SIZE_RESET = 9'd256;

    // operation codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // pool selector codes
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    // configuration register indexes
    localparam logic REG_BLOCK_POOL_SIZE = 1'b0;
    localparam logic REG_INODE_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [ENTRY_W-1:0] entry_index;
    } tpba_req_t;

    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] granted_index;
    } tpba_rsp_t;

endpackage

>>> sv/two_pool_bitmap_allocator.sv
// Top level of the two-pool first-fit bitmap allocator.
//
// A request runs in an accept step and a modify step: the accept cycle picks
// the map word to read (for an allocate, the lowest word not yet full, from a
// per-word summary held in flip-flops) and issues the read; the next cycle finds
// the lowest clear bit or the bit to free, writes the word back and loads the
// result register. The registered read of each pool's map RAM sets this split;
// a result left untaken holds the block in its modify step until the output
// register drains. Both maps come out of reset all free at once, as
// unwritten words read as free through per-word valid flags, so no clearing
// pass is needed. Pool sizes above MAX_BLOCKS or MAX_INODES act as the maximum;
// a pool size of zero fails every request on that pool. Configuration writes
// are taken in any cycle but must only be issued while the block is idle.
module two_pool_bitmap_allocator #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MAX_INODES = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] entry_index, [15:10] zero
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] pool

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] granted_index, [18:10] free_inodes,
                                   // [29:19] free_blocks, [31:30] zero
    output logic        m_tuser,   // [0] ok

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    import tpba_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_MODIFY = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic                     pool_reg;
    logic [BLOCK_SIZE_W-1:0]  block_size_reg;
    logic [INODE_SIZE_W-1:0]  inode_size_reg;

    logic                     out_valid_reg;
    tpba_rsp_t                out_rsp_reg;
    logic [INODE_FREE_W-1:0]  out_free_inodes_reg;
    logic [BLOCK_FREE_W-1:0]  out_free_blocks_reg;

    tpba_req_t                req;
    tpba_rsp_t                inode_rsp;
    tpba_rsp_t                block_rsp;
    logic [INODE_FREE_W-1:0]  free_inodes;
    logic [BLOCK_FREE_W-1:0]  free_blocks;
    logic                     accept;
    logic                     out_room;
    logic                     commit;

    assign req.cmd         = s_tuser[0];
    assign req.entry_index = s_tdata[ENTRY_W-1:0];

    // one request in flight; the result register frees the input side
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_room = !out_valid_reg || m_tready;
    assign commit   = (state_reg == ST_MODIFY) && out_room;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                // hold here until the result register can take the answer
                if (out_room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tpba_pool #(
        .MAX_ENTRIES (MAX_INODES),
        .SIZE_W      (INODE_SIZE_W),
        .FREE_W      (INODE_FREE_W)
    ) u_inode_pool (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && (s_tuser[1] == POOL_INODE)),
        .req        (req),
        .commit     (commit && (pool_reg == POOL_INODE)),
        .size_cfg   (inode_size_reg),
        .rsp        (inode_rsp),
        .free_after (free_inodes)
    );

    tpba_pool #(
        .MAX_ENTRIES (MAX_BLOCKS),
        .SIZE_W      (BLOCK_SIZE_W),
        .FREE_W      (BLOCK_FREE_W)
    ) u_block_pool (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && (s_tuser[1] == POOL_BLOCK)),
        .req        (req),
        .commit     (commit && (pool_reg == POOL_BLOCK)),
        .size_cfg   (block_size_reg),
        .rsp        (block_rsp),
        .free_after (free_blocks)
    );

    // configuration registers: every write is taken at once
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            block_size_reg <= BLOCK_SIZE_RESET;
            inode_size_reg <= INODE_SIZE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                // drop the result once the transaction completes
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BLOCK_POOL_SIZE: block_size_reg <= cfg_data;
                    REG_INODE_POOL_SIZE: inode_size_reg <= cfg_data[INODE_SIZE_W-1:0];
                    default:             block_size_reg <= block_size_reg;
                endcase
            end
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pool_reg <= s_tuser[1];
        end
        if (commit)
        begin
            out_rsp_reg         <= (pool_reg == POOL_BLOCK) ? block_rsp : inode_rsp;
            out_free_inodes_reg <= free_inodes;
            out_free_blocks_reg <= free_blocks;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.ok;
    assign m_tdata  = {2'b00, out_free_blocks_reg, out_free_inodes_reg,
                       out_rsp_reg.granted_index};

endmodule

>>> sv/tpba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tpba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tpba_pool.sv
// One allocation pool: word-wide usage map in RAM, per-word full summary,
// first-free search and in-use count.
module tpba_pool #(
    parameter int MAX_ENTRIES = 1024,
    parameter int SIZE_W      = 11,
    parameter int FREE_W      = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tpba_pkg::tpba_req_t  req,
    input  logic                 commit,
    input  logic [SIZE_W-1:0]    size_cfg,
    output tpba_pkg::tpba_rsp_t  rsp,
    output logic [FREE_W-1:0]    free_after
);

    import tpba_pkg::*;

    localparam int WORDS = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
    localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int IDXW  = AW + BIT_W;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int M1    = IDXW > CW ? IDXW : CW;
    localparam int M2    = M1 > SIZE_W ? M1 : SIZE_W;
    localparam int CMPW  = M2 > ENTRY_W ? M2 : ENTRY_W;

    // per-word flags: full marks a word with every bit used, valid marks a
    // word written since reset (an unwritten word reads as all free)
    logic [WORDS-1:0]   full_reg;
    logic [WORDS-1:0]   valid_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    tpba_req_t          req_reg;
    logic [AW-1:0]      addr_reg;
    logic               any_reg;

    logic [AW-1:0]      first_word;
    logic [AW+ENTRY_W-1:0] idx_ext;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rdata;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  new_word;
    logic [BIT_W-1:0]   zero_bit;
    logic [IDXW-1:0]    alloc_idx;
    logic [CMPW-1:0]    size_c;
    logic [CMPW-1:0]    max_c;
    logic [CMPW-1:0]    eff_c;
    logic [CMPW-1:0]    count_c;
    logic [CMPW-1:0]    free_c;
    logic               alloc_ok;
    logic               free_ok;
    logic               hit;
    logic               we;

    // lowest word that still holds a free entry
    always_comb
    begin
        first_word = '0;
        for (int w = WORDS - 1; w >= 0; w--)
        begin
            if (!full_reg[w])
            begin
                first_word = AW'(w);
            end
        end
    end

    assign idx_ext = {{AW{1'b0}}, req.entry_index};
    assign rd_addr = (req.cmd == CMD_ALLOC) ? first_word : idx_ext[BIT_W +: AW];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg  <= req;
            addr_reg <= rd_addr;
            any_reg  <= ~&full_reg;
        end
    end

    tpba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr_reg),
        .wdata (new_word),
        .re    (start),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign word = valid_reg[addr_reg] ? rdata : '0;

    // lowest clear bit of the fetched word
    always_comb
    begin
        zero_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!word[b])
            begin
                zero_bit = BIT_W'(b);
            end
        end
    end

    assign alloc_idx = {addr_reg, zero_bit};
    assign size_c    = CMPW'(size_cfg);
    assign max_c     = CMPW'(MAX_ENTRIES);
    assign eff_c     = (size_c > max_c) ? max_c : size_c;
    assign alloc_ok  = any_reg && (CMPW'(alloc_idx) < eff_c);
    assign free_ok   = CMPW'(req_reg.entry_index) < eff_c;
    assign hit       = word[req_reg.entry_index[BIT_W-1:0]];

    always_comb
    begin
        if (req_reg.cmd == CMD_ALLOC)
        begin
            new_word = word | (WORD_W'(1) << zero_bit);
            we       = commit && alloc_ok;
        end
        else
        begin
            new_word = word & ~(WORD_W'(1) << req_reg.entry_index[BIT_W-1:0]);
            we       = commit && free_ok && hit;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit && (req_reg.cmd == CMD_ALLOC) && alloc_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (commit && (req_reg.cmd == CMD_FREE) && free_ok && hit
                 && (count_reg != '0))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= '0;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (we)
            begin
                full_reg[addr_reg]  <= &new_word;
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    assign count_c = CMPW'(count_next);
    assign free_c  = (eff_c > count_c) ? (eff_c - count_c) : '0;

    assign free_after        = FREE_W'(free_c);
    assign rsp.ok            = (req_reg.cmd == CMD_ALLOC) ? alloc_ok : free_ok;
    assign rsp.granted_index = ((req_reg.cmd == CMD_ALLOC) && alloc_ok)
                               ? ENTRY_W'(alloc_idx) : '0;

endmodule
